### src/tagged_handle_slot_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the handle slot table
// ----------------------------------------------------------------------------
`ifndef TAGGED_HANDLE_SLOT_TABLE_MACROS_SVH
`define TAGGED_HANDLE_SLOT_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define THST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("handle table assertion failed");

// next-cycle implication, disabled during reset
`define THST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("handle table assertion failed");

`endif

### src/thst_pkg.sv
// ----------------------------------------------------------------------------
// thst_pkg
// Shared widths, codes and types of the handle slot table.
// ----------------------------------------------------------------------------
package thst_pkg;

  localparam int unsigned ID_W      = 16;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned IN_IDX_W  = 7;
  localparam int unsigned OUT_IDX_W = 6;
  localparam int unsigned LIVE_W    = 7;
  localparam int unsigned STAT_W    = 3;

  localparam int SLOTS_DEF  = 64;
  localparam int MAX_ID_DEF = 32767;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_ID_BIG   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_IDX_RNG  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;
  localparam logic [STAT_W-1:0] STAT_MISMATCH = 3'd5;

  typedef struct packed {
    logic capture;
    logic execute;
  } thst_cmd_t;

endpackage

### src/thst_free_find.sv
// ----------------------------------------------------------------------------
// thst_free_find
// Lowest free slot search: registered per-group summary, then group select.
// ----------------------------------------------------------------------------
module thst_free_find
  import thst_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [SLOTS-1:0]           valid_i,
  output logic                       found_o,
  output logic [$clog2(SLOTS)-1:0]   index_o
);

  localparam int IW = $clog2(SLOTS);
  localparam int GS = 8;
  localparam int NG = (SLOTS + GS - 1) / GS;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;

  logic [NG*GS-1:0] pad;
  logic [NG-1:0]    grp_any_d, grp_any_q;
  logic [2:0]       grp_off_d [NG];
  logic [2:0]       grp_off_q [NG];
  logic [GW-1:0]    sel;

  for (genvar b = 0; b < NG*GS; b++) begin : g_pad
    if (b < SLOTS) begin : g_real
      assign pad[b] = valid_i[b];
    end else begin : g_fill
      assign pad[b] = 1'b1;
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_d[g] = 1'b0;
      grp_off_d[g] = 3'd0;
      for (int j = GS - 1; j >= 0; j--) begin
        if (!pad[g*GS + j]) begin
          grp_any_d[g] = 1'b1;
          grp_off_d[g] = 3'(j);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_any_q <= '0;
    end else begin
      grp_any_q <= grp_any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_off_q <= grp_off_d;
  end

  always_comb begin
    sel = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        sel = GW'(g);
      end
    end
  end

  assign found_o = |grp_any_q;
  assign index_o = IW'(32'(sel) * GS + 32'(grp_off_q[sel]));

endmodule

### src/thst_ctrl.sv
// ----------------------------------------------------------------------------
// thst_ctrl
// Two-step controller: capture a transaction, then execute it into the
// output register once that register is free.
// ----------------------------------------------------------------------------
module thst_ctrl
  import thst_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output thst_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free      = !out_valid_q || !out_stall_i;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign cmd_o.capture = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.execute = (state_q == ST_RUN) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/thst_dpath.sv
// ----------------------------------------------------------------------------
// thst_dpath
// Slot valid bits, tag memory, id counter, occupancy count and result
// register of the handle slot table.
// ----------------------------------------------------------------------------
module thst_dpath
  import thst_pkg::*;
#(
  parameter int SLOTS  = SLOTS_DEF,
  parameter int MAX_ID = MAX_ID_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  thst_cmd_t            cmd_i,
  input  logic                 cfg_we_i,
  input  logic [ID_W-1:0]      cfg_wdata_i,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [ID_W-1:0]      entry_id_i,
  input  logic [IN_IDX_W-1:0]  entry_index_i,
  output logic [STAT_W-1:0]    status_o,
  output logic [ID_W-1:0]      handle_id_o,
  output logic [OUT_IDX_W-1:0] handle_index_o,
  output logic [LIVE_W-1:0]    live_count_o
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [REQ_W-1:0]    req_q;
  logic [ID_W-1:0]     id_q;
  logic [IN_IDX_W-1:0] idx_q;
  logic [ID_W-1:0]     tag_rd_q;
  logic [ID_W-1:0]     tag_mem [SLOTS];

  logic [SLOTS-1:0]    valid_q, valid_d;
  logic [ID_W-1:0]     ctr_q, ctr_d;
  logic [CW-1:0]       cnt_q, cnt_d;

  logic                free_found;
  logic [IW-1:0]       free_idx;
  logic [IW-1:0]       slot;
  logic                in_range;
  logic                slot_valid;
  logic [ID_W-1:0]     fresh;
  logic                tag_we;

  logic [STAT_W-1:0]    stat_d, stat_q;
  logic [ID_W-1:0]      hid_d, hid_q;
  logic [OUT_IDX_W-1:0] hidx_d, hidx_q;
  logic [LIVE_W-1:0]    live_q;

  thst_free_find #(
    .SLOTS (SLOTS)
  ) u_free_find (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_q),
    .found_o (free_found),
    .index_o (free_idx)
  );

  assign slot       = IW'(idx_q);
  assign in_range   = (32'(idx_q) < SLOTS);
  assign slot_valid = in_range && valid_q[slot];
  assign fresh      = (32'(ctr_q) >= MAX_ID) ? ID_W'(1) : ctr_q + ID_W'(1);

  always_comb begin
    valid_d = valid_q;
    ctr_d   = ctr_q;
    cnt_d   = cnt_q;
    tag_we  = 1'b0;
    stat_d  = STAT_OK;
    hid_d   = '0;
    hidx_d  = idx_q[OUT_IDX_W-1:0];
    case (req_q)
      REQ_INSERT: begin
        hidx_d = '0;
        if (!free_found) begin
          stat_d = STAT_FULL;
        end else begin
          hid_d             = fresh;
          hidx_d            = OUT_IDX_W'(free_idx);
          valid_d[free_idx] = 1'b1;
          ctr_d             = fresh;
          cnt_d             = cnt_q + CW'(1);
          tag_we            = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (!in_range) begin
          stat_d = STAT_IDX_RNG;
        end else if (!slot_valid) begin
          stat_d = STAT_EMPTY;
        end else begin
          valid_d[slot] = 1'b0;
          cnt_d         = cnt_q - CW'(1);
        end
      end
      REQ_LOOKUP: begin
        if (32'(id_q) > MAX_ID) begin
          stat_d = STAT_ID_BIG;
        end else if (!in_range) begin
          stat_d = STAT_IDX_RNG;
        end else if (!slot_valid) begin
          stat_d = STAT_EMPTY;
        end else if (tag_rd_q != id_q) begin
          stat_d = STAT_MISMATCH;
        end else begin
          hid_d = id_q;
        end
      end
      default: begin
        hidx_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ctr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      if (cmd_i.execute) begin
        valid_q <= valid_d;
        cnt_q   <= cnt_d;
      end
      if (cfg_we_i) begin
        ctr_q <= cfg_wdata_i;
      end else if (cmd_i.execute) begin
        ctr_q <= ctr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      id_q  <= entry_id_i;
      idx_q <= entry_index_i;
    end
    if (cmd_i.execute) begin
      stat_q <= stat_d;
      hid_q  <= hid_d;
      hidx_q <= hidx_d;
      live_q <= LIVE_W'(cnt_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && tag_we) begin
      tag_mem[free_idx] <= fresh;
    end
    if (cmd_i.capture) begin
      tag_rd_q <= tag_mem[IW'(entry_index_i)];
    end
  end

  assign status_o       = stat_q;
  assign handle_id_o    = hid_q;
  assign handle_index_o = hidx_q;
  assign live_count_o   = live_q;

endmodule

### src/tagged_handle_slot_table.sv
// ----------------------------------------------------------------------------
// tagged_handle_slot_table
// Generational handle table: insert, remove by slot and lookup by id and slot.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o) carries req_type_i, entry_id_i
//   and entry_index_i; a transaction is taken when valid is high and stall
//   is low. Result channel (out_valid_o / out_stall_i) carries status_o,
//   handle_id_o, handle_index_o and live_count_o, one result per request.
//   Each request passes the controller's capture step (tag memory read,
//   registered free-slot summary) and then its execute step, which loads
//   the result into the output register; a new request is taken only after
//   the current one has executed.
//   A stalled result holds; the controller waits in its execute step until
//   the output register frees, then takes the next request.
//   cfg_we_i loads the id counter from cfg_wdata_i; write only when idle.
//   Reset empties every slot, clears the count and the id counter; the tag
//   memory keeps no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "tagged_handle_slot_table_macros.svh"

module tagged_handle_slot_table
  import thst_pkg::*;
#(
  parameter int SLOTS  = SLOTS_DEF,
  parameter int MAX_ID = MAX_ID_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [ID_W-1:0]      cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [ID_W-1:0]      entry_id_i,
  input  logic [IN_IDX_W-1:0]  entry_index_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STAT_W-1:0]    status_o,
  output logic [ID_W-1:0]      handle_id_o,
  output logic [OUT_IDX_W-1:0] handle_index_o,
  output logic [LIVE_W-1:0]    live_count_o
);

  thst_cmd_t cmd;

  thst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  thst_dpath #(
    .SLOTS  (SLOTS),
    .MAX_ID (MAX_ID)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req_type_i),
    .entry_id_i     (entry_id_i),
    .entry_index_i  (entry_index_i),
    .status_o       (status_o),
    .handle_id_o    (handle_id_o),
    .handle_index_o (handle_index_o),
    .live_count_o   (live_count_o)
  );

  `THST_ASSERT_NXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o)
  `THST_ASSERT_NXT(a_exec_loads_out, cmd.execute, out_valid_o)
  `THST_ASSERT_IMP(a_err_zero_id, out_valid_o && (status_o != STAT_OK), handle_id_o == '0)
  `THST_ASSERT_IMP(a_id_bound, out_valid_o && (status_o == STAT_OK), 32'(handle_id_o) <= MAX_ID)

endmodule
